@@ rtl/grid_line_of_sight_top_defines.svh @@
// ----------------------------------------------------------------------------
// Grid line-of-sight assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_TOP_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define GLOS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid_line_of_sight: assertion failed");

// next-cycle implication, disabled during reset
`define GLOS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid_line_of_sight: assertion failed");

`else

`define GLOS_ASSERT_IMP(lbl, ante, cons)
`define GLOS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/glos_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid line-of-sight package
// Request/response types and shared constants.
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned GRID_ROWS_DEF = 64;

  localparam int unsigned CELL_W = 6;  // cell index fields of a write
  localparam int unsigned VTX_W  = 7;  // vertex coordinate fields of a query

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic              cell_is_blocked;
    logic [VTX_W-1:0]  from_row;
    logic [VTX_W-1:0]  from_col;
    logic [VTX_W-1:0]  to_row;
    logic [VTX_W-1:0]  to_col;
  } in_req_t;

  typedef struct packed {
    logic visible;
    logic was_write;
  } out_rsp_t;

endpackage

@@ rtl/glos_map.sv @@
// ----------------------------------------------------------------------------
// Grid line-of-sight map store
// One-bit-per-cell obstacle bitmap, single address, registered read data.
// ----------------------------------------------------------------------------
module glos_map import glos_pkg::*; #(
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF,
  localparam int unsigned ROW_W    = $clog2(GRID_ROWS),
  localparam int unsigned COL_W    = $clog2(GRID_COLS)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  input  logic             wdata_i,
  output logic             rdata_o
);

  logic mem_q [GRID_ROWS][GRID_COLS];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[row_i][col_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[row_i][col_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/grid_line_of_sight_top.sv @@
// ----------------------------------------------------------------------------
// Grid line-of-sight unit
// Obstacle bitmap with a Bresenham-style line-of-sight walker.
// ----------------------------------------------------------------------------
// A write request stores one map cell; its acknowledge passes from the ST_FIN
// state, which waits while the output register holds an untaken answer, into
// the output register. A query request walks the line one step along its
// major axis per iteration; each step probes at most two map cells through
// the single map port, and each probe is issued and then evaluated from the
// registered map read data. The walk stops early at the first blocked cell,
// or for an axis-aligned line at the first step whose two flank cells are
// both blocked. Cells outside the map count as blocked.
// One request is in flight at a time; the next is taken once the answer has
// moved to the output register, even while that answer waits to be taken.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_top_defines.svh"

module grid_line_of_sight_top import glos_pkg::*; #(
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned ROW_W = $clog2(GRID_ROWS);
  localparam int unsigned COL_W = $clog2(GRID_COLS);
  localparam int unsigned CRD_W = VTX_W + 1;  // signed, covers -1 .. 2**VTX_W-1

  typedef logic signed [CRD_W-1:0] crd_t;

  localparam crd_t CRD_POS = crd_t'(1);
  localparam crd_t CRD_NEG = crd_t'(-1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_STEP = 8'b0000_0010,
    ST_EVA  = 8'b0000_0100,
    ST_MID  = 8'b0000_1000,
    ST_EVB  = 8'b0001_0000,
    ST_EVF1 = 8'b0010_0000,
    ST_EVF2 = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  // minor-axis offset of a probe
  typedef enum logic [1:0] {
    PRB_OFS  = 2'b00,  // travel-direction cell offset
    PRB_ZERO = 2'b01,  // first flank
    PRB_DOWN = 2'b10   // second flank
  } prb_sel_e;

  state_e state_q, state_d;

  logic             hor_q, hor_d;         // major axis is the column
  logic             maj_neg_q, maj_neg_d;
  logic             min_neg_q, min_neg_d;
  logic [VTX_W-1:0] dmaj_q, dmaj_d;
  logic [VTX_W-1:0] dmin_q, dmin_d;
  logic [VTX_W-1:0] f_q, f_d;
  crd_t             maj_q, maj_d;
  crd_t             min_q, min_d;
  crd_t             maj_end_q, maj_end_d;
  logic             vis_q, vis_d;
  logic             wr_q, wr_d;
  logic             flank_q, flank_d;
  logic             oob_q;

  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, out_rsp_d;

  prb_sel_e   prb_sel;
  crd_t       prb_maj, prb_min, prb_row, prb_col;
  logic       prb_in_map;
  logic       map_rdata, blk;
  logic       map_we;
  logic [ROW_W-1:0] map_row;
  logic [COL_W-1:0] map_col;

  crd_t       maj_nxt;
  logic       at_end;
  logic [VTX_W:0] fsum;

  logic       acc;
  crd_t       fr, fc, tr, tc;
  logic signed [CRD_W-1:0] drow, dcol;
  logic [VTX_W-1:0] adrow, adcol;
  logic       wr_in_map;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // query set-up
  assign fr    = $signed({1'b0, in_req_i.from_row});
  assign fc    = $signed({1'b0, in_req_i.from_col});
  assign tr    = $signed({1'b0, in_req_i.to_row});
  assign tc    = $signed({1'b0, in_req_i.to_col});
  assign drow  = tr - fr;
  assign dcol  = tc - fc;
  assign adrow = drow[CRD_W-1] ? VTX_W'(-drow) : VTX_W'(drow);
  assign adcol = dcol[CRD_W-1] ? VTX_W'(-dcol) : VTX_W'(dcol);

  assign wr_in_map = (int'(in_req_i.cell_row) < GRID_ROWS) &&
                     (int'(in_req_i.cell_col) < GRID_COLS);

  // probe address, shared by every cell test of the walk
  always_comb begin
    prb_maj = maj_q + (maj_neg_q ? CRD_NEG : crd_t'(0));
    case (prb_sel)
      PRB_OFS:  prb_min = min_q + (min_neg_q ? CRD_NEG : crd_t'(0));
      PRB_ZERO: prb_min = min_q;
      PRB_DOWN: prb_min = min_q + CRD_NEG;
      default:  prb_min = min_q;
    endcase
    prb_row = hor_q ? prb_min : prb_maj;
    prb_col = hor_q ? prb_maj : prb_min;
  end

  assign prb_in_map = !prb_row[CRD_W-1] && !prb_col[CRD_W-1] &&
                      (int'(prb_row) < GRID_ROWS) && (int'(prb_col) < GRID_COLS);

  always_comb begin
    if (state_q == ST_IDLE) begin
      map_row = ROW_W'(in_req_i.cell_row);
      map_col = COL_W'(in_req_i.cell_col);
    end else begin
      map_row = ROW_W'(prb_row);
      map_col = COL_W'(prb_col);
    end
  end

  assign map_we = acc && (in_req_i.func == FUNC_WRITE) && wr_in_map;

  glos_map #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .row_i   (map_row),
    .col_i   (map_col),
    .wdata_i (in_req_i.cell_is_blocked),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i) begin
    oob_q <= !prb_in_map;
  end

  assign blk     = oob_q || map_rdata;
  assign maj_nxt = maj_q + (maj_neg_q ? CRD_NEG : CRD_POS);
  assign at_end  = (maj_nxt == maj_end_q);
  assign fsum    = {1'b0, f_q} + {1'b0, dmin_q};

  always_comb begin
    state_d   = state_q;
    hor_d     = hor_q;
    maj_neg_d = maj_neg_q;
    min_neg_d = min_neg_q;
    dmaj_d    = dmaj_q;
    dmin_d    = dmin_q;
    f_d       = f_q;
    maj_d     = maj_q;
    min_d     = min_q;
    maj_end_d = maj_end_q;
    vis_d     = vis_q;
    wr_d      = wr_q;
    flank_d   = flank_q;
    prb_sel   = PRB_OFS;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_req_i.func == FUNC_WRITE) begin
            wr_d    = 1'b1;
            vis_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            wr_d      = 1'b0;
            vis_d     = 1'b1;
            f_d       = '0;
            hor_d     = (adcol >= adrow);
            maj_d     = (adcol >= adrow) ? fc : fr;
            min_d     = (adcol >= adrow) ? fr : fc;
            maj_end_d = (adcol >= adrow) ? tc : tr;
            dmaj_d    = (adcol >= adrow) ? adcol : adrow;
            dmin_d    = (adcol >= adrow) ? adrow : adcol;
            maj_neg_d = (adcol >= adrow) ? dcol[CRD_W-1] : drow[CRD_W-1];
            min_neg_d = (adcol >= adrow) ? drow[CRD_W-1] : dcol[CRD_W-1];
            // zero-length line is trivially clear
            if ((adcol == '0) && (adrow == '0)) begin
              state_d = ST_FIN;
            end else begin
              state_d = ST_STEP;
            end
          end
        end
      end
      ST_STEP: begin
        if (fsum >= {1'b0, dmaj_q}) begin
          f_d     = VTX_W'(fsum - {1'b0, dmaj_q});
          state_d = ST_EVA;  // probe issued this cycle
        end else begin
          f_d     = VTX_W'(fsum);
          state_d = ST_MID;
        end
      end
      ST_EVA: begin
        if (blk) begin
          vis_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          min_d   = min_q + (min_neg_q ? CRD_NEG : CRD_POS);
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        if (f_q != '0) begin
          state_d = ST_EVB;
        end else if (dmin_q == '0) begin
          prb_sel = PRB_ZERO;
          state_d = ST_EVF1;
        end else begin
          maj_d   = maj_nxt;
          state_d = at_end ? ST_FIN : ST_STEP;
        end
      end
      ST_EVB: begin
        if (blk) begin
          vis_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          maj_d   = maj_nxt;
          state_d = at_end ? ST_FIN : ST_STEP;
        end
      end
      ST_EVF1: begin
        flank_d = blk;
        prb_sel = PRB_DOWN;
        state_d = ST_EVF2;
      end
      ST_EVF2: begin
        // axis-aligned line is blocked only when both flanks are blocked
        if (flank_q && blk) begin
          vis_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          maj_d   = maj_nxt;
          state_d = at_end ? ST_FIN : ST_STEP;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_rsp_d.visible   = vis_q;
          out_rsp_d.was_write = wr_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hor_q     <= hor_d;
    maj_neg_q <= maj_neg_d;
    min_neg_q <= min_neg_d;
    dmaj_q    <= dmaj_d;
    dmin_q    <= dmin_d;
    f_q       <= f_d;
    maj_q     <= maj_d;
    min_q     <= min_d;
    maj_end_q <= maj_end_d;
    vis_q     <= vis_d;
    wr_q      <= wr_d;
    flank_q   <= flank_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `GLOS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `GLOS_ASSERT_IMP(a_step_in_range, state_q == ST_STEP, (maj_q != maj_end_q) && (f_q < dmaj_q))
  `GLOS_ASSERT_NXT(a_fin_delivers, (state_q == ST_FIN) && !out_valid_q, out_valid_o && in_ready_o)

endmodule
